@@ sv/eba_pkg.sv @@
`timescale 1ns / 1ps
package eba_pkg;
  localparam int MEM_BYTES = 65536;
  localparam int MEM_AW = $clog2(MEM_BYTES);
  localparam logic [15:0] RESET_PC = 16'h0200;
  localparam logic [7:0] RESET_SP = 8'hFF;
  localparam logic [7:0] STACK_PAGE = 8'h01;

  localparam logic [1:0] FUNC_WRITE = 2'd0;
  localparam logic [1:0] FUNC_READ = 2'd1;
  localparam logic [1:0] FUNC_EXEC = 2'd2;

  localparam logic [1:0] OUT_RUN = 2'd0;
  localparam logic [1:0] OUT_BRK = 2'd1;
  localparam logic [1:0] OUT_BAD = 2'd2;

  localparam logic [7:0] FL_N = 8'h80;
  localparam logic [7:0] FL_V = 8'h40;
  localparam logic [7:0] FL_Z = 8'h02;
  localparam logic [7:0] FL_C = 8'h01;

  localparam logic [7:0] OP_BRK = 8'h00;
  localparam logic [7:0] OP_BPL = 8'h10;
  localparam logic [7:0] OP_BNE = 8'hD0;
  localparam logic [7:0] OP_BEQ = 8'hF0;
  localparam logic [7:0] OP_CLC = 8'h18;
  localparam logic [7:0] OP_JSR = 8'h20;
  localparam logic [7:0] OP_JMP = 8'h4C;
  localparam logic [7:0] OP_RTS = 8'h60;
  localparam logic [7:0] OP_AND_IMM = 8'h29;
  localparam logic [7:0] OP_EOR_ABX = 8'h5D;
  localparam logic [7:0] OP_ADC_IMM = 8'h69;
  localparam logic [7:0] OP_SBC_IMM = 8'hE9;
  localparam logic [7:0] OP_PHA = 8'h48;
  localparam logic [7:0] OP_PLA = 8'h68;
  localparam logic [7:0] OP_STA_ZP = 8'h85;
  localparam logic [7:0] OP_STA_ZPX = 8'h95;
  localparam logic [7:0] OP_STA_ABS = 8'h8D;
  localparam logic [7:0] OP_STA_ABY = 8'h99;
  localparam logic [7:0] OP_TXA = 8'h8A;
  localparam logic [7:0] OP_TXS = 8'h9A;
  localparam logic [7:0] OP_TSX = 8'hBA;
  localparam logic [7:0] OP_LDY_IMM = 8'hA0;
  localparam logic [7:0] OP_LDX_IMM = 8'hA2;
  localparam logic [7:0] OP_LDX_ZP = 8'hA6;
  localparam logic [7:0] OP_LDA_IMM = 8'hA9;
  localparam logic [7:0] OP_LDA_ZP = 8'hA5;
  localparam logic [7:0] OP_LDA_ZPX = 8'hB5;
  localparam logic [7:0] OP_LDA_IZX = 8'hA1;
  localparam logic [7:0] OP_LDA_IZY = 8'hB1;
  localparam logic [7:0] OP_LDA_ABS = 8'hAD;
  localparam logic [7:0] OP_LDA_ABX = 8'hBD;
  localparam logic [7:0] OP_LDA_ABY = 8'hB9;
  localparam logic [7:0] OP_INY = 8'hC8;
  localparam logic [7:0] OP_INX = 8'hE8;
  localparam logic [7:0] OP_DEX = 8'hCA;
  localparam logic [7:0] OP_CPX_IMM = 8'hE0;
  localparam logic [7:0] OP_CPX_ZP = 8'hE4;
  localparam logic [7:0] OP_CMP_IMM = 8'hC9;
  localparam logic [7:0] OP_CMP_ZP = 8'hC5;
  localparam logic [7:0] OP_CMP_ABS = 8'hCD;
  localparam logic [7:0] OP_NOP = 8'hEA;

  typedef struct packed {
    logic [1:0] func;
    logic [15:0] byte_addr;
    logic [7:0] mem_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0] outcome;
    logic [7:0] read_byte;
    logic [15:0] prog_counter;
    logic [7:0] acc_value;
    logic [7:0] x_value;
    logic [7:0] y_value;
    logic [7:0] sp_value;
    logic [7:0] flag_bits;
  } out_item_t;

  typedef struct packed {
    logic we;
    logic [15:0] addr;
    logic [7:0] wdata;
  } mem_req_t;
endpackage

@@ sv/eba_if.sv @@
`timescale 1ns / 1ps
interface eba_in_if;
  logic valid;
  logic ready;
  eba_pkg::in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface eba_out_if;
  logic valid;
  logic ready;
  eba_pkg::out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface eba_cfg_if;
  logic valid;
  logic ready;
  logic [15:0] data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

@@ sv/eight_bit_accumulator_cpu_subset.sv @@
`timescale 1ns / 1ps
// Small 6502-subset processor with a private 64 KiB byte memory.
// The in_ channel carries one transaction per request: write a byte, read a
// byte, or execute the instruction at the program counter. Every request
// returns one transaction on the out_ channel with the outcome, the byte read
// and all registers. The cfg_ channel loads the start program counter and
// also sets the program counter at once; write it only while idle.
// Every byte access goes through the single memory port, which does one byte
// access per cycle; an instruction reads its opcode, operand, pointer and data
// bytes there in turn, as many as it needs.
// One request is in flight at a time; the next is taken once the previous
// result has left the output register.
// After reset the memory is cleared one byte per cycle, while in_ready and
// cfg_ready stay low.
// If the receiver stalls, the result is held and no new request is taken.
module eight_bit_accumulator_cpu_subset (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] in_func,
  input  logic [15:0] in_byte_addr,
  input  logic [7:0] in_mem_data,
  output logic out_valid,
  input  logic out_ready,
  output logic [1:0] out_outcome,
  output logic [7:0] out_read_byte,
  output logic [15:0] out_prog_counter,
  output logic [7:0] out_acc_value,
  output logic [7:0] out_x_value,
  output logic [7:0] out_y_value,
  output logic [7:0] out_sp_value,
  output logic [7:0] out_flag_bits,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [15:0] cfg_start_pc
);
  import eba_pkg::*;
  eba_in_if in_ch();
  eba_out_if out_ch();
  eba_cfg_if cfg_ch();
  mem_req_t req;
  logic [7:0] rdata;

  assign in_ch.valid = in_valid;
  assign in_ch.data = '{func: in_func, byte_addr: in_byte_addr, mem_data: in_mem_data};
  assign in_ready = in_ch.ready;
  assign out_valid = out_ch.valid;
  assign out_ch.ready = out_ready;
  assign out_outcome = out_ch.data.outcome;
  assign out_read_byte = out_ch.data.read_byte;
  assign out_prog_counter = out_ch.data.prog_counter;
  assign out_acc_value = out_ch.data.acc_value;
  assign out_x_value = out_ch.data.x_value;
  assign out_y_value = out_ch.data.y_value;
  assign out_sp_value = out_ch.data.sp_value;
  assign out_flag_bits = out_ch.data.flag_bits;
  assign cfg_ch.valid = cfg_valid;
  assign cfg_ch.data = cfg_start_pc;
  assign cfg_ready = cfg_ch.ready;

  eba_core u_core (.clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
                   .cfg_ch(cfg_ch.sink), .mem_req(req), .mem_rdata(rdata));
  eba_mem u_mem (.clk(clk), .req(req), .rdata(rdata));
endmodule

@@ sv/eba_mem.sv @@
`timescale 1ns / 1ps
module eba_mem (
  input  logic clk,
  input  eba_pkg::mem_req_t req,
  output logic [7:0] rdata
);
  import eba_pkg::*;
  logic [7:0] mem [MEM_BYTES];
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.addr[MEM_AW-1:0]] <= req.wdata;
    end
    rdata <= mem[req.addr[MEM_AW-1:0]];
  end
endmodule

@@ sv/eba_core.sv @@
`timescale 1ns / 1ps
module eba_core (
  input  logic clk,
  input  logic rst_n,
  eba_in_if.sink in_ch,
  eba_out_if.source out_ch,
  eba_cfg_if.sink cfg_ch,
  output eba_pkg::mem_req_t mem_req,
  input  logic [7:0] mem_rdata
);
  import eba_pkg::*;

  localparam logic [3:0] S_CLR = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_OP = 4'd2;
  localparam logic [3:0] S_B1 = 4'd3;
  localparam logic [3:0] S_B2 = 4'd4;
  localparam logic [3:0] S_P1 = 4'd5;
  localparam logic [3:0] S_DATA = 4'd6;
  localparam logic [3:0] S_RD = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;
  localparam logic [3:0] S_WAIT = 4'd9;
  localparam logic [3:0] S_S2 = 4'd10;

  logic [3:0] st_r, st_nxt;
  logic [MEM_AW:0] clr_r, clr_nxt;
  logic [15:0] pc_r, pc_nxt;
  logic [7:0] a_r, a_nxt, x_r, x_nxt, y_r, y_nxt, sp_r, sp_nxt, p_r, p_nxt;
  logic [7:0] op_r, op_nxt, b1_r, b1_nxt, b2_r, b2_nxt, rb_r, rb_nxt;
  logic [1:0] oc_r, oc_nxt;
  logic ov_r, ov_nxt;
  mem_req_t rq;

  logic [15:0] pc1, pc2, pc3;
  logic [8:0] sum;
  logic [7:0] mv, cmpr, ares;
  logic [8:0] cdiff;

  assign in_ch.ready = (st_r == S_IDLE) && !ov_r;
  assign cfg_ch.ready = (st_r != S_CLR);
  assign out_ch.valid = ov_r;
  assign out_ch.data = '{outcome: oc_r, read_byte: rb_r, prog_counter: pc_r,
                         acc_value: a_r, x_value: x_r, y_value: y_r,
                         sp_value: sp_r, flag_bits: p_r};
  assign mem_req = rq;
  assign pc1 = pc_r + 16'd1;
  assign pc2 = pc_r + 16'd2;
  assign pc3 = pc_r + 16'd3;

  function automatic logic [7:0] nz(input logic [7:0] f, input logic [7:0] v);
    nz = (f & ~(FL_N | FL_Z)) | (v[7] ? FL_N : 8'h00) | (v == 8'h00 ? FL_Z : 8'h00);
  endfunction

  always_comb begin
    st_nxt = st_r; clr_nxt = clr_r; pc_nxt = pc_r;
    a_nxt = a_r; x_nxt = x_r; y_nxt = y_r; sp_nxt = sp_r; p_nxt = p_r;
    op_nxt = op_r; b1_nxt = b1_r; b2_nxt = b2_r; rb_nxt = rb_r; oc_nxt = oc_r;
    ov_nxt = ov_r;
    rq = '{we: 1'b0, addr: pc_r, wdata: a_r};
    mv = mem_rdata; cmpr = a_r; ares = 8'h00; sum = 9'h000; cdiff = 9'h000;
    if (out_ch.valid && out_ch.ready) ov_nxt = 1'b0;
    if (cfg_ch.valid && cfg_ch.ready) begin
      pc_nxt = cfg_ch.data;
    end
    unique case (st_r)
      S_CLR: begin
        rq = '{we: 1'b1, addr: clr_r[15:0], wdata: 8'h00};
        clr_nxt = clr_r + 1'b1;
        if (clr_r == (MEM_AW + 1)'(MEM_BYTES - 1)) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_ch.valid && !ov_r) begin
          rq.addr = in_ch.data.byte_addr;
          oc_nxt = OUT_RUN; rb_nxt = 8'h00;
          unique case (in_ch.data.func)
            FUNC_WRITE: begin
              rq.we = 1'b1; rq.wdata = in_ch.data.mem_data; st_nxt = S_DONE;
            end
            FUNC_READ: st_nxt = S_RD;
            FUNC_EXEC: begin rq.addr = pc_r; st_nxt = S_OP; end
            default: st_nxt = S_DONE;
          endcase
        end
      end
      S_RD: begin rb_nxt = mem_rdata; st_nxt = S_DONE; end
      S_OP: begin
        op_nxt = mem_rdata; rq.addr = pc1; st_nxt = S_B1;
        unique case (mem_rdata)
          OP_BRK: begin oc_nxt = OUT_BRK; st_nxt = S_DONE; end
          OP_CLC: begin p_nxt = p_r & ~FL_C; pc_nxt = pc1; st_nxt = S_DONE; end
          OP_NOP: begin pc_nxt = pc1; st_nxt = S_DONE; end
          OP_TXA: begin
            a_nxt = x_r; p_nxt = nz(p_r, x_r); pc_nxt = pc1; st_nxt = S_DONE;
          end
          OP_TXS: begin sp_nxt = x_r; pc_nxt = pc1; st_nxt = S_DONE; end
          OP_TSX: begin
            x_nxt = sp_r; p_nxt = nz(p_r, sp_r); pc_nxt = pc1; st_nxt = S_DONE;
          end
          OP_INY: begin
            y_nxt = y_r + 8'd1; p_nxt = nz(p_r, y_r + 8'd1); pc_nxt = pc1; st_nxt = S_DONE;
          end
          OP_INX: begin
            x_nxt = x_r + 8'd1; p_nxt = nz(p_r, x_r + 8'd1); pc_nxt = pc1; st_nxt = S_DONE;
          end
          OP_DEX: begin
            x_nxt = x_r - 8'd1; p_nxt = nz(p_r, x_r - 8'd1); pc_nxt = pc1; st_nxt = S_DONE;
          end
          OP_PHA: begin
            rq = '{we: 1'b1, addr: {STACK_PAGE, sp_r}, wdata: a_r};
            sp_nxt = sp_r - 8'd1; pc_nxt = pc1; st_nxt = S_DONE;
          end
          OP_PLA: begin
            rq.addr = {STACK_PAGE, sp_r + 8'd1}; sp_nxt = sp_r + 8'd1;
            pc_nxt = pc1; st_nxt = S_DATA;
          end
          OP_RTS: begin
            rq.addr = {STACK_PAGE, sp_r + 8'd1}; sp_nxt = sp_r + 8'd1; st_nxt = S_P1;
          end
          OP_BPL, OP_BNE, OP_BEQ, OP_JSR, OP_JMP, OP_AND_IMM, OP_EOR_ABX, OP_ADC_IMM,
          OP_SBC_IMM, OP_STA_ZP, OP_STA_ZPX, OP_STA_ABS, OP_STA_ABY, OP_LDY_IMM,
          OP_LDX_IMM, OP_LDX_ZP, OP_LDA_IMM, OP_LDA_ZP, OP_LDA_ZPX, OP_LDA_IZX,
          OP_LDA_IZY, OP_LDA_ABS, OP_LDA_ABX, OP_LDA_ABY, OP_CPX_IMM, OP_CPX_ZP,
          OP_CMP_IMM, OP_CMP_ZP, OP_CMP_ABS: ;
          default: begin oc_nxt = OUT_BAD; st_nxt = S_DONE; end
        endcase
      end
      S_P1: begin
        b1_nxt = mem_rdata; rq.addr = {STACK_PAGE, sp_r + 8'd1}; sp_nxt = sp_r + 8'd1;
        st_nxt = S_WAIT;
      end
      S_WAIT: begin pc_nxt = {mem_rdata, b1_r} + 16'd1; st_nxt = S_DONE; end
      S_B1: begin
        b1_nxt = mem_rdata; rq.addr = pc2; st_nxt = S_DONE; pc_nxt = pc2;
        unique case (op_r)
          OP_BPL, OP_BNE, OP_BEQ: begin
            if ((op_r == OP_BPL && !p_r[7]) || (op_r == OP_BNE && !p_r[1]) ||
                (op_r == OP_BEQ && p_r[1]))
              pc_nxt = pc2 + {{8{mem_rdata[7]}}, mem_rdata};
          end
          OP_AND_IMM: begin a_nxt = a_r & mem_rdata; p_nxt = nz(p_r, a_r & mem_rdata); end
          OP_ADC_IMM, OP_SBC_IMM: begin
            mv = (op_r == OP_SBC_IMM) ? ~mem_rdata : mem_rdata;
            sum = {1'b0, a_r} + {1'b0, mv} + {8'h00, p_r[0]};
            a_nxt = sum[7:0];
            p_nxt = nz(p_r & ~(FL_V | FL_C), sum[7:0]) | (sum[8] ? FL_C : 8'h00) |
                    ((~(a_r ^ mv) & (a_r ^ sum[7:0]) & 8'h80) != 8'h00 ? FL_V : 8'h00);
          end
          OP_LDY_IMM: begin y_nxt = mem_rdata; p_nxt = nz(p_r, mem_rdata); end
          OP_LDX_IMM: begin x_nxt = mem_rdata; p_nxt = nz(p_r, mem_rdata); end
          OP_LDA_IMM: begin a_nxt = mem_rdata; p_nxt = nz(p_r, mem_rdata); end
          OP_CPX_IMM, OP_CMP_IMM: begin
            cmpr = (op_r == OP_CPX_IMM) ? x_r : a_r;
            cdiff = {1'b0, cmpr} - {1'b0, mem_rdata};
            p_nxt = nz(p_r & ~FL_C, cdiff[7:0]) | (cdiff[8] ? 8'h00 : FL_C);
          end
          OP_STA_ZP: rq = '{we: 1'b1, addr: {8'h00, mem_rdata}, wdata: a_r};
          OP_STA_ZPX: rq = '{we: 1'b1, addr: {8'h00, mem_rdata + x_r}, wdata: a_r};
          OP_LDX_ZP, OP_LDA_ZP, OP_CPX_ZP, OP_CMP_ZP: begin
            rq.addr = {8'h00, mem_rdata}; st_nxt = S_DATA;
          end
          OP_LDA_ZPX: begin rq.addr = {8'h00, mem_rdata + x_r}; st_nxt = S_DATA; end
          OP_LDA_IZX: begin
            rq.addr = {8'h00, mem_rdata + x_r}; b1_nxt = mem_rdata + x_r; st_nxt = S_S2;
          end
          OP_LDA_IZY: begin rq.addr = {8'h00, mem_rdata}; st_nxt = S_S2; end
          default: begin pc_nxt = pc_r; st_nxt = S_B2; end
        endcase
      end
      S_S2: begin
        // Pointer low byte arrives; fetch the high byte within page zero.
        b2_nxt = mem_rdata; rq.addr = {8'h00, b1_r + 8'd1}; st_nxt = S_B2;
      end
      S_B2: begin
        if (op_r == OP_LDA_IZX || op_r == OP_LDA_IZY) begin
          rq.addr = {mem_rdata, b2_r} + ((op_r == OP_LDA_IZY) ? {8'h00, y_r} : 16'h0000);
          st_nxt = S_DATA;
        end else begin
          b2_nxt = mem_rdata; pc_nxt = pc3; st_nxt = S_DONE;
          unique case (op_r)
            OP_JMP: pc_nxt = {mem_rdata, b1_r};
            OP_JSR: begin
              rq = '{we: 1'b1, addr: {STACK_PAGE, sp_r}, wdata: pc2[15:8]};
              sp_nxt = sp_r - 8'd1; pc_nxt = {mem_rdata, b1_r}; st_nxt = S_P1;
              b1_nxt = pc2[7:0];
            end
            OP_STA_ABS: rq = '{we: 1'b1, addr: {mem_rdata, b1_r}, wdata: a_r};
            OP_STA_ABY: rq = '{we: 1'b1, addr: {mem_rdata, b1_r} + {8'h00, y_r}, wdata: a_r};
            OP_LDA_ABS, OP_CMP_ABS: begin rq.addr = {mem_rdata, b1_r}; st_nxt = S_DATA; end
            OP_LDA_ABX, OP_EOR_ABX: begin
              rq.addr = {mem_rdata, b1_r} + {8'h00, x_r}; st_nxt = S_DATA;
            end
            OP_LDA_ABY: begin rq.addr = {mem_rdata, b1_r} + {8'h00, y_r}; st_nxt = S_DATA; end
            default: ;
          endcase
        end
      end
      S_DATA: begin
        st_nxt = S_DONE;
        unique case (op_r)
          OP_LDX_ZP: begin x_nxt = mem_rdata; p_nxt = nz(p_r, mem_rdata); end
          OP_CPX_ZP, OP_CMP_ZP, OP_CMP_ABS: begin
            cmpr = (op_r == OP_CPX_ZP) ? x_r : a_r;
            cdiff = {1'b0, cmpr} - {1'b0, mem_rdata};
            p_nxt = nz(p_r & ~FL_C, cdiff[7:0]) | (cdiff[8] ? 8'h00 : FL_C);
          end
          OP_EOR_ABX: begin ares = a_r ^ mem_rdata; a_nxt = ares; p_nxt = nz(p_r, ares); end
          default: begin a_nxt = mem_rdata; p_nxt = nz(p_r, mem_rdata); end
        endcase
      end
      S_DONE: begin ov_nxt = 1'b1; st_nxt = S_IDLE; end
      default: st_nxt = S_IDLE;
    endcase
    // The second JSR push uses the stack state slot.
    if (st_r == S_P1 && op_r == OP_JSR) begin
      rq = '{we: 1'b1, addr: {STACK_PAGE, sp_r}, wdata: b1_r};
      sp_nxt = sp_r - 8'd1; b1_nxt = b1_r; st_nxt = S_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; clr_r <= '0; pc_r <= RESET_PC;
      a_r <= 8'h00; x_r <= 8'h00; y_r <= 8'h00; sp_r <= RESET_SP; p_r <= 8'h00;
      ov_r <= 1'b0; oc_r <= OUT_RUN;
    end else begin
      st_r <= st_nxt; clr_r <= clr_nxt; pc_r <= pc_nxt;
      a_r <= a_nxt; x_r <= x_nxt; y_r <= y_nxt; sp_r <= sp_nxt; p_r <= p_nxt;
      ov_r <= ov_nxt; oc_r <= oc_nxt;
    end
    op_r <= op_nxt; b1_r <= b1_nxt; b2_r <= b2_nxt; rb_r <= rb_nxt;
  end
endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import eba_pkg::*;

  localparam logic [1:0] FUNC_NONE = 2'd3;

  logic [7:0] op_list[41] = '{OP_BRK, OP_BPL, OP_BNE, OP_BEQ, OP_CLC, OP_JSR, OP_JMP,
    OP_RTS, OP_AND_IMM, OP_EOR_ABX, OP_ADC_IMM, OP_SBC_IMM, OP_PHA, OP_PLA, OP_STA_ZP,
    OP_STA_ZPX, OP_STA_ABS, OP_STA_ABY, OP_TXA, OP_TXS, OP_TSX, OP_LDY_IMM, OP_LDX_IMM,
    OP_LDX_ZP, OP_LDA_IMM, OP_LDA_ZP, OP_LDA_ZPX, OP_LDA_IZX, OP_LDA_IZY, OP_LDA_ABS,
    OP_LDA_ABX, OP_LDA_ABY, OP_INY, OP_INX, OP_DEX, OP_CPX_IMM, OP_CPX_ZP, OP_CMP_IMM,
    OP_CMP_ZP, OP_CMP_ABS, OP_NOP};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #4 clk = ~clk;

  eba_in_if in_ch();
  eba_out_if out_ch();
  eba_cfg_if cfg_ch();

  eight_bit_accumulator_cpu_subset dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_func(in_ch.data.func), .in_byte_addr(in_ch.data.byte_addr),
    .in_mem_data(in_ch.data.mem_data),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_outcome(out_ch.data.outcome), .out_read_byte(out_ch.data.read_byte),
    .out_prog_counter(out_ch.data.prog_counter), .out_acc_value(out_ch.data.acc_value),
    .out_x_value(out_ch.data.x_value), .out_y_value(out_ch.data.y_value),
    .out_sp_value(out_ch.data.sp_value), .out_flag_bits(out_ch.data.flag_bits),
    .cfg_valid(cfg_ch.valid), .cfg_ready(cfg_ch.ready), .cfg_start_pc(cfg_ch.data)
  );

  logic [7:0] mem_img[65536];
  logic [15:0] pc_q;
  logic [7:0] a_q, x_q, y_q, sp_q, p_q;
  out_item_t cpu_results[$];
  int mismatches = 0;
  int n_sent = 0;
  int n_checked = 0;
  int n_exec = 0;
  int n_brk = 0;
  int n_bad = 0;
  bit sink_stalls = 1'b1;
  bit source_gaps = 1'b1;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [7:0] set_nz(logic [7:0] v);
    p_q[7] = v[7];
    p_q[1] = (v == 8'h00);
    return v;
  endfunction

  function automatic void cmp_flags(logic [7:0] r, logic [7:0] m);
    logic [7:0] d;
    d = r - m;
    p_q[0] = (r >= m);
    p_q[1] = (r == m);
    p_q[7] = d[7];
  endfunction

  function automatic void add_with_carry(logic [7:0] m);
    logic [8:0] s;
    s = {1'b0, a_q} + {1'b0, m} + {8'h00, p_q[0]};
    p_q[0] = s[8];
    p_q[6] = ~(a_q[7] ^ m[7]) & (a_q[7] ^ s[7]);
    a_q = set_nz(s[7:0]);
  endfunction

  function automatic void push_byte(logic [7:0] v);
    mem_img[{8'h01, sp_q}] = v;
    sp_q = sp_q - 8'd1;
  endfunction

  function automatic logic [7:0] pull_byte();
    sp_q = sp_q + 8'd1;
    return mem_img[{8'h01, sp_q}];
  endfunction

  function automatic logic [15:0] zp_word(logic [7:0] z);
    logic [7:0] z1;
    z1 = z + 8'd1;
    return {mem_img[{8'h00, z1}], mem_img[{8'h00, z}]};
  endfunction

  function automatic logic [1:0] run_opcode();
    logic [7:0] op, b1, b2, lo, hi;
    logic [15:0] w, nxt, ret;
    logic [7:0] zx;
    logic [15:0] len;
    op = mem_img[pc_q];
    b1 = mem_img[pc_q + 16'd1];
    b2 = mem_img[pc_q + 16'd2];
    w = {b2, b1};
    nxt = pc_q + 16'd2;
    zx = b1 + x_q;
    len = 16'd1;
    case (op)
      OP_BRK: return OUT_BRK;
      OP_BPL, OP_BNE, OP_BEQ: begin
        if ((op == OP_BPL && !p_q[7]) || (op == OP_BNE && !p_q[1]) ||
            (op == OP_BEQ && p_q[1]))
          nxt = nxt + {{8{b1[7]}}, b1};
        pc_q = nxt;
        return OUT_RUN;
      end
      OP_JSR: begin
        ret = pc_q + 16'd2;
        push_byte(ret[15:8]);
        push_byte(ret[7:0]);
        pc_q = w;
        return OUT_RUN;
      end
      OP_JMP: begin
        pc_q = w;
        return OUT_RUN;
      end
      OP_RTS: begin
        lo = pull_byte();
        hi = pull_byte();
        pc_q = {hi, lo} + 16'd1;
        return OUT_RUN;
      end
      OP_CLC: p_q[0] = 1'b0;
      OP_AND_IMM: begin a_q = set_nz(a_q & b1); len = 16'd2; end
      OP_EOR_ABX: begin a_q = set_nz(a_q ^ mem_img[w + {8'h00, x_q}]); len = 16'd3; end
      OP_ADC_IMM: begin add_with_carry(b1); len = 16'd2; end
      OP_SBC_IMM: begin add_with_carry(~b1); len = 16'd2; end
      OP_PHA: push_byte(a_q);
      OP_PLA: a_q = set_nz(pull_byte());
      OP_STA_ZP: begin mem_img[{8'h00, b1}] = a_q; len = 16'd2; end
      OP_STA_ZPX: begin mem_img[{8'h00, zx}] = a_q; len = 16'd2; end
      OP_STA_ABS: begin mem_img[w] = a_q; len = 16'd3; end
      OP_STA_ABY: begin mem_img[w + {8'h00, y_q}] = a_q; len = 16'd3; end
      OP_TXA: a_q = set_nz(x_q);
      OP_TXS: sp_q = x_q;
      OP_TSX: x_q = set_nz(sp_q);
      OP_LDY_IMM: begin y_q = set_nz(b1); len = 16'd2; end
      OP_LDX_IMM: begin x_q = set_nz(b1); len = 16'd2; end
      OP_LDX_ZP: begin x_q = set_nz(mem_img[{8'h00, b1}]); len = 16'd2; end
      OP_LDA_IMM: begin a_q = set_nz(b1); len = 16'd2; end
      OP_LDA_ZP: begin a_q = set_nz(mem_img[{8'h00, b1}]); len = 16'd2; end
      OP_LDA_ZPX: begin a_q = set_nz(mem_img[{8'h00, zx}]); len = 16'd2; end
      OP_LDA_IZX: begin a_q = set_nz(mem_img[zp_word(zx)]); len = 16'd2; end
      OP_LDA_IZY: begin a_q = set_nz(mem_img[zp_word(b1) + {8'h00, y_q}]); len = 16'd2; end
      OP_LDA_ABS: begin a_q = set_nz(mem_img[w]); len = 16'd3; end
      OP_LDA_ABX: begin a_q = set_nz(mem_img[w + {8'h00, x_q}]); len = 16'd3; end
      OP_LDA_ABY: begin a_q = set_nz(mem_img[w + {8'h00, y_q}]); len = 16'd3; end
      OP_INY: y_q = set_nz(y_q + 8'd1);
      OP_INX: x_q = set_nz(x_q + 8'd1);
      OP_DEX: x_q = set_nz(x_q - 8'd1);
      OP_CPX_IMM: begin cmp_flags(x_q, b1); len = 16'd2; end
      OP_CPX_ZP: begin cmp_flags(x_q, mem_img[{8'h00, b1}]); len = 16'd2; end
      OP_CMP_IMM: begin cmp_flags(a_q, b1); len = 16'd2; end
      OP_CMP_ZP: begin cmp_flags(a_q, mem_img[{8'h00, b1}]); len = 16'd2; end
      OP_CMP_ABS: begin cmp_flags(a_q, mem_img[w]); len = 16'd3; end
      OP_NOP: ;
      default: return OUT_BAD;
    endcase
    pc_q = pc_q + len;
    return OUT_RUN;
  endfunction

  function automatic out_item_t predict_request(in_item_t r);
    out_item_t o;
    o.outcome = OUT_RUN;
    o.read_byte = 8'h00;
    case (r.func)
      FUNC_WRITE: mem_img[r.byte_addr] = r.mem_data;
      FUNC_READ: o.read_byte = mem_img[r.byte_addr];
      FUNC_EXEC: begin
        o.outcome = run_opcode();
        n_exec++;
        if (o.outcome == OUT_BRK) n_brk++;
        if (o.outcome == OUT_BAD) n_bad++;
      end
      default: ;
    endcase
    o.prog_counter = pc_q;
    o.acc_value = a_q;
    o.x_value = x_q;
    o.y_value = y_q;
    o.sp_value = sp_q;
    o.flag_bits = p_q;
    return o;
  endfunction

  task automatic send_request(logic [1:0] f, logic [15:0] addr, logic [7:0] d);
    in_item_t r;
    int gap;
    r.func = f;
    r.byte_addr = addr;
    r.mem_data = d;
    in_ch.valid <= 1'b1;
    in_ch.data <= r;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    cpu_results.push_back(predict_request(r));
    n_sent++;
    gap = source_gaps ? pick_gap() : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (cpu_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_start_pc(logic [15:0] v);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    pc_q = v;
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_instr(logic [7:0] op, logic [7:0] b1, logic [7:0] b2);
    logic [15:0] p;
    p = pc_q;
    send_request(FUNC_WRITE, p, op);
    send_request(FUNC_WRITE, p + 16'd1, b1);
    send_request(FUNC_WRITE, p + 16'd2, b2);
    send_request(FUNC_EXEC, 16'($urandom()), 8'($urandom()));
  endtask

  always @(posedge clk) begin
    out_item_t e, g;
    if (out_ch.valid && out_ch.ready) begin
      g = out_ch.data;
      if (cpu_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction %p", g);
      end else begin
        e = cpu_results.pop_front();
        n_checked++;
        if (g.outcome !== e.outcome || g.read_byte !== e.read_byte ||
            g.prog_counter !== e.prog_counter || g.acc_value !== e.acc_value ||
            g.x_value !== e.x_value || g.y_value !== e.y_value ||
            g.sp_value !== e.sp_value || g.flag_bits !== e.flag_bits) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch at %0t on result %0d", $realtime, n_checked);
            $display("  expected %p", e);
            $display("  actual   %p", g);
          end
        end
      end
    end
  end

  initial begin
    int run;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      run = $urandom_range(1, 20);
      out_ch.ready <= 1'b1;
      repeat (run) @(posedge clk);
      if (sink_stalls) begin
        run = pick_gap();
        if (run > 0) begin
          out_ch.ready <= 1'b0;
          repeat (run) @(posedge clk);
        end
      end
    end
  end

  task automatic test_memory_access();
    send_request(FUNC_READ, 16'h0000, 8'h00);
    send_request(FUNC_WRITE, 16'hFFFF, 8'hFF);
    send_request(FUNC_WRITE, 16'h0000, 8'hA5);
    send_request(FUNC_READ, 16'hFFFF, 8'hFF);
    send_request(FUNC_READ, 16'h0000, 8'h5A);
    send_request(FUNC_NONE, 16'hFFFF, 8'hFF);
    send_request(FUNC_NONE, 16'h0000, 8'h00);
  endtask

  task automatic test_flag_corners();
    run_instr(OP_LDA_IMM, 8'h7F, 8'h00);
    run_instr(OP_ADC_IMM, 8'h01, 8'h00);
    run_instr(OP_SBC_IMM, 8'h01, 8'h00);
    run_instr(OP_ADC_IMM, 8'hFF, 8'h00);
    run_instr(OP_CMP_IMM, 8'hFF, 8'h00);
    run_instr(OP_BNE, 8'h80, 8'h00);
    run_instr(OP_BRK, 8'h00, 8'h00);
  endtask

  task automatic test_every_opcode();
    foreach (op_list[i]) run_instr(op_list[i], 8'($urandom()), 8'($urandom()));
    run_instr(8'hFF, 8'h00, 8'h00);
  endtask

  task automatic test_random_programs(int n);
    int r;
    logic [7:0] op;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        send_request(FUNC_WRITE, 16'($urandom_range(0, 15) < 10 ? $urandom_range(0, 255) :
                     $urandom()), 8'($urandom()));
      end else if (r < 12) begin
        send_request(FUNC_READ, 16'($urandom()), 8'($urandom()));
      end else if (r < 13) begin
        send_request(FUNC_NONE, 16'($urandom()), 8'($urandom()));
      end else begin
        r = $urandom_range(0, 99);
        if (r < 6) op = 8'($urandom());
        else if (r < 8) op = OP_BRK;
        else op = op_list[$urandom_range(1, 40)];
        run_instr(op, 8'($urandom()), 8'($urandom()));
      end
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    foreach (mem_img[i]) mem_img[i] = 8'h00;
    pc_q = RESET_PC;
    a_q = 8'h00;
    x_q = 8'h00;
    y_q = 8'h00;
    sp_q = RESET_SP;
    p_q = 8'h00;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_memory_access();
    test_flag_corners();
    test_every_opcode();
    write_start_pc(16'hFFFF);
    test_every_opcode();
    write_start_pc(16'h0000);
    test_random_programs(40);
    write_start_pc(16'($urandom()));
    source_gaps = 1'b0;
    sink_stalls = 1'b0;
    test_random_programs(40);
    source_gaps = 1'b1;
    sink_stalls = 1'b1;
    write_start_pc(16'h0200);
    test_random_programs(136);
    drain();

    $display("Covered %0d transactions, %0d instructions (%0d BRK, %0d unknown).",
             n_sent, n_exec, n_brk, n_bad);
    $display("Checked %0d results over several start addresses and random programs.",
             n_checked);
    if (mismatches == 0 && cpu_results.size() == 0) begin
      $display("eight_bit_accumulator_cpu_subset test passed");
    end else begin
      $display("eight_bit_accumulator_cpu_subset test failed");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("eight_bit_accumulator_cpu_subset test failed");
    $finish;
  end
endmodule
